### rtl/bie_pkg.sv
// ----------------------------------------------------------------------------
// bie_pkg
// Shared types and constants of the bitmap index engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bie_pkg;

  localparam int VAL_W    = 4;
  localparam int ROW_W    = 12;
  localparam int CNT_W    = 13;
  localparam int CARD     = 16;
  localparam int MAX_ROWS = 4096;

  typedef logic [CARD-1:0] word_t;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_UPDATE = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_COUNT  = 3'd3,
    MODE_LOOKUP = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOOP  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [ROW_W-1:0] row_id;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] count;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/bie_ram.sv
// ----------------------------------------------------------------------------
// bie_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bie_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/bitmap_index_engine.sv
// ----------------------------------------------------------------------------
// bitmap_index_engine
// Equality-encoded bitmap index: one row word per row, one bit per value.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid / in_stall  in_data  (in_item_t)
//  out_      output     out_valid / out_stall out_data (out_item_t)
//
//  Append, unknown modes and rows beyond the count give a result in the cycle
//  after the transfer; update, remove and lookup go through the S_RMW state,
//  set by one read-modify-write of the row RAM. Count walks the S_SCAN state,
//  one RAM read per stored row. Reset clears the row count, state and result
//  valid but not the RAM: rows at or beyond the count are never read, so the
//  RAM needs no clearing pass. A stalled result holds off the next transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_index_engine
  import bie_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] row_count_r, row_count_nxt;
  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             load_out;
  logic             in_accept;

  logic             mem_we;
  logic [ROW_W-1:0] mem_waddr;
  word_t            mem_wdata;
  logic             mem_re;
  logic [ROW_W-1:0] mem_raddr;
  word_t            mem_rdata;

  logic             has;
  logic [VAL_W-1:0] cur;
  logic             issue;

  bie_ram #(
    .ADDR_W(ROW_W),
    .DATA_W(CARD)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    has = 1'b0;
    cur = '0;
    for (int i = CARD - 1; i >= 0; i--) begin
      if (mem_rdata[i]) begin
        has = 1'b1;
        cur = VAL_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    item_nxt      = item_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = item_r.row_id;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = in_data.row_id;
    issue         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          item_nxt = in_data;
          out_nxt  = '0;
          unique case (mode_t'(in_data.mode))
            MODE_APPEND: begin
              load_out = 1'b1;
              if (row_count_r == CNT_W'(MAX_ROWS)) begin
                out_nxt.status = ST_FULL;
              end else begin
                out_nxt.status = ST_OK;
                mem_we         = 1'b1;
                mem_waddr      = row_count_r[ROW_W-1:0];
                mem_wdata      = word_t'(1) << in_data.value;
                row_count_nxt  = row_count_r + CNT_W'(1);
              end
            end
            MODE_UPDATE, MODE_REMOVE, MODE_LOOKUP: begin
              if ({1'b0, in_data.row_id} >= row_count_r) begin
                load_out       = 1'b1;
                out_nxt.status = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_RMW;
              end
            end
            MODE_COUNT: begin
              scan_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              load_out       = 1'b1;
              out_nxt.status = ST_NOOP;
            end
          endcase
        end
      end
      S_RMW: begin
        load_out  = 1'b1;
        state_nxt = S_IDLE;
        out_nxt   = '0;
        if (!has) begin
          out_nxt.status = ST_NOOP;
        end else begin
          out_nxt.status = ST_OK;
          unique case (mode_t'(item_r.mode))
            MODE_LOOKUP: begin
              out_nxt.found       = 1'b1;
              out_nxt.found_value = cur;
            end
            MODE_REMOVE: begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata & ~(word_t'(1) << cur);
            end
            MODE_UPDATE: begin
              out_nxt.found_value = cur;
              if (item_r.value == cur) begin
                out_nxt.status = ST_NOOP;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = (mem_rdata & ~(word_t'(1) << cur))
                            | (word_t'(1) << item_r.value);
              end
            end
            default: begin
              out_nxt.status = ST_NOOP;
            end
          endcase
        end
      end
      S_SCAN: begin
        issue     = scan_r < row_count_r;
        mem_re    = issue;
        mem_raddr = scan_r[ROW_W-1:0];
        scan_nxt  = scan_r + CNT_W'(issue);
        pend_nxt  = issue;
        if (pend_r && mem_rdata[item_r.value]) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (!issue && !pend_r) begin
          load_out      = 1'b1;
          state_nxt     = S_IDLE;
          out_nxt       = '0;
          out_nxt.count = cnt_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    scan_r <= scan_nxt;
    cnt_r  <= cnt_nxt;
    out_r  <= out_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= CNT_W'(MAX_ROWS))
    else $error("Row count exceeds the table size.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && out_valid_r |-> !out_stall)
    else $error("A held result was overwritten.");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> {1'b0, mem_waddr} <= row_count_r)
    else $error("Row write beyond the stored rows.");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("Transfer taken while an item is in progress.");

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap index engine. A directed table covers
// the empty table, reserved modes, empty rows and same-value updates. Random
// traffic then grows the table and keeps working on it, with a heavier share
// of appends at the end. A behavioral model of the row store tracks every
// result and gives the expected one where a table row carries none.
// ----------------------------------------------------------------------------

module tb_top
  import bie_pkg::*;
;

  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  word_t       row_words [MAX_ROWS];
  int unsigned rows_held;

  out_item_t   pending_results [$];
  dir_row_t    directed_tab [$];
  out_item_t   want_res;
  int unsigned errors;
  int unsigned sent_total;
  int unsigned rx_cycles;
  int unsigned stall_left;
  int unsigned idle_cycles;
  bit          tx_quiet;
  bit          rx_quiet;

  bitmap_index_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int lowest_set(input word_t w);
    for (int i = 0; i < CARD; i++) begin
      if (w[i]) return i;
    end
    return -1;
  endfunction

  function automatic out_item_t index_apply(input in_item_t it);
    out_item_t   r;
    int          cur;
    int unsigned n;
    r = '0;
    r.status = ST_OK;
    case (it.mode)
      MODE_APPEND: begin
        if (rows_held >= MAX_ROWS) begin
          r.status = ST_FULL;
        end else begin
          row_words[rows_held] = word_t'(1) << it.value;
          rows_held++;
        end
      end
      MODE_UPDATE, MODE_REMOVE, MODE_LOOKUP: begin
        if (it.row_id >= rows_held) begin
          r.status = ST_RANGE;
        end else begin
          cur = lowest_set(row_words[it.row_id]);
          if (cur < 0) begin
            r.status = ST_NOOP;
          end else begin
            r.found_value = VAL_W'(cur);
            if (it.mode == MODE_LOOKUP) begin
              r.found = 1'b1;
            end else if (it.mode == MODE_REMOVE) begin
              row_words[it.row_id][cur] = 1'b0;
              r.found_value = '0;
            end else if (it.value == cur) begin
              r.status = ST_NOOP;
            end else begin
              row_words[it.row_id][cur] = 1'b0;
              row_words[it.row_id][it.value] = 1'b1;
            end
          end
        end
      end
      MODE_COUNT: begin
        n = 0;
        for (int unsigned k = 0; k < rows_held; k++) begin
          if (row_words[k][it.value]) n++;
        end
        r.count = CNT_W'(n);
      end
      default: begin
        r.status = ST_NOOP;
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned idle_len(input bit quiet);
    int unsigned w;
    w = $urandom_range(0, 99);
    if (quiet || w < 55) return 0;
    if (w < 90) return $urandom_range(1, 3);
    if (w < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t rand_item(input int unsigned p_app, input int unsigned p_cnt);
    in_item_t    it;
    int unsigned w;
    int unsigned sel;
    int          cur;
    w = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    it.row_id = ROW_W'($urandom_range(0, MAX_ROWS - 1));
    if (rows_held > 0 && $urandom_range(0, 9) != 0) begin
      it.row_id = ROW_W'($urandom_range(0, rows_held - 1));
    end
    it.value = VAL_W'($urandom_range(0, CARD - 1));
    if (w < p_app) begin
      it.mode = MODE_APPEND;
    end else if (w < p_app + p_cnt) begin
      it.mode = MODE_COUNT;
    end else if (w >= 95) begin
      it.mode = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    end else if (sel < 4) begin
      it.mode = MODE_UPDATE;
    end else if (sel < 6) begin
      it.mode = MODE_REMOVE;
    end else begin
      it.mode = MODE_LOOKUP;
    end
    if (it.mode == MODE_UPDATE && it.row_id < rows_held && $urandom_range(0, 3) == 0) begin
      cur = lowest_set(row_words[it.row_id]);
      if (cur >= 0) it.value = VAL_W'(cur);
    end
    return it;
  endfunction

  function automatic dir_row_t table_row(input logic [2:0] m, input int r, input int v,
                                         input bit typed, input status_t st, input bit f,
                                         input int fv, input int c);
    dir_row_t d;
    d.item.mode = m;
    d.item.row_id = ROW_W'(r);
    d.item.value = VAL_W'(v);
    d.typed = typed;
    d.res.status = st;
    d.res.found = f;
    d.res.found_value = VAL_W'(fv);
    d.res.count = CNT_W'(c);
    return d;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    int unsigned gap;
    out_item_t   res;
    if (sent_total % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    sent_total++;
    gap = idle_len(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = index_apply(it);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  always @(posedge clk) begin
    rx_cycles++;
    if (rx_cycles % 200 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error("result transfer with no result expected");
      end else begin
        want_res = pending_results.pop_front();
        if (out_data.status != want_res.status)
          report_error($sformatf("status got %0d want %0d", out_data.status,
                                 want_res.status));
        if (out_data.found != want_res.found)
          report_error($sformatf("found got %0d want %0d", out_data.found,
                                 want_res.found));
        if (out_data.found_value != want_res.found_value)
          report_error($sformatf("found_value got %0d want %0d", out_data.found_value,
                                 want_res.found_value));
        if (out_data.count != want_res.count)
          report_error($sformatf("count got %0d want %0d", out_data.count,
                                 want_res.count));
      end
    end
    if (stall_left == 0) stall_left = idle_len(rx_quiet);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_item_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    rows_held = 0;
    errors = 0;
    sent_total = 0;
    rx_cycles = 0;
    stall_left = 0;
    idle_cycles = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    directed_tab.push_back(table_row(MODE_LOOKUP, 0, 0, 1, ST_RANGE, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_UPDATE, 0, 5, 1, ST_RANGE, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_REMOVE, 4095, 15, 1, ST_RANGE, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_COUNT, 0, 0, 1, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_COUNT, 4095, 15, 1, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_RSVD5, 0, 0, 1, ST_NOOP, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_RSVD7, 4095, 15, 1, ST_NOOP, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_APPEND, 0, 0, 1, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_APPEND, 4095, 15, 1, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_APPEND, 0, 15, 1, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_LOOKUP, 0, 0, 1, ST_OK, 1, 0, 0));
    directed_tab.push_back(table_row(MODE_LOOKUP, 1, 0, 1, ST_OK, 1, 15, 0));
    directed_tab.push_back(table_row(MODE_COUNT, 0, 15, 1, ST_OK, 0, 0, 2));
    directed_tab.push_back(table_row(MODE_UPDATE, 1, 15, 1, ST_NOOP, 0, 15, 0));
    directed_tab.push_back(table_row(MODE_UPDATE, 1, 3, 1, ST_OK, 0, 15, 0));
    directed_tab.push_back(table_row(MODE_LOOKUP, 1, 0, 0, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_REMOVE, 0, 0, 1, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_LOOKUP, 0, 0, 1, ST_NOOP, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_UPDATE, 0, 5, 1, ST_NOOP, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_REMOVE, 0, 0, 1, ST_NOOP, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_LOOKUP, 3, 0, 1, ST_RANGE, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_RSVD6, 2, 9, 1, ST_NOOP, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_COUNT, 0, 0, 0, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_APPEND, 0, 7, 0, ST_OK, 0, 0, 0));
    directed_tab.push_back(table_row(MODE_UPDATE, 3, 7, 0, ST_OK, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_tab[i]) send_item(directed_tab[i].item, directed_tab[i].typed,
                                        directed_tab[i].res);

    // Grow a modest table and work on it, then lean toward appends.
    repeat (1100) send_item(rand_item(18, 7), 1'b0, none);
    repeat (175) send_item(rand_item(40, 5), 1'b0, none);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
